>>> rtl/sal_pkg.sv
package sal_pkg;

   localparam int ENT_W            = 4;
   localparam int ENT_NUM          = 16;
   localparam int COORD_W          = 16;
   localparam int RAD_W            = 15;
   localparam int LIM_W            = 4;
   localparam int KIND_W           = 3;
   localparam int OP_W             = 2;
   localparam int MAX_ENTITIES_DEF = 16;

   localparam logic [OP_W-1:0] OP_ENTER = 2'd0;
   localparam logic [OP_W-1:0] OP_LEAVE = 2'd1;
   localparam logic [OP_W-1:0] OP_MOVE  = 2'd2;
   localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

   localparam logic [KIND_W-1:0] KIND_ENTER = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LEAVE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MOVE  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_NEAR  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DONE  = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]           operation;
      logic [ENT_W-1:0]          entity;
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic [LIM_W-1:0]          query_limit;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic [ENT_W-1:0]          subject;
      logic [ENT_W-1:0]          object;
      logic signed [COORD_W-1:0] event_x;
      logic signed [COORD_W-1:0] event_y;
      logic                      status;
      logic [LIM_W-1:0]          found_count;
      logic                      is_last;
   } rsp_type;

   typedef struct packed {
      logic                      used;
      logic [ENT_W-1:0]          entity;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } slot_type;

   typedef struct packed {
      logic load;
      logic take_left;
      logic take_right;
   } cell_cmd_type;

   typedef struct packed {
      logic x_ge;
      logic hit;
   } cell_flag_type;

endpackage

>>> rtl/sorted_list_area_of_interest_unit.sv
// Area-of-interest tracker over a row of cells that keep the entity list sorted by x.
// A transaction is taken when start is high and busy is low. Its events come out on
// rsp_strobe and rsp_payload at most one per cycle and end with a done item. The receiver
// cannot stall them. The neighbor walk reads, squares and compares every slot it visits,
// except the slot that ends a side of the walk, which it only reads. The second event of
// each enter or leave pair is sent from a state of its own, and enter and leave each take
// a state for the list shift. Busy drops in the same cycle as the done item appears on the
// ports, so the next transaction can be taken while the done item is there. A move runs
// two walks with a removal and an insertion between them. It then replays each old neighbor
// with two events, and each new neighbor that was not an old one with two enter events.
module sorted_list_area_of_interest_unit #(
   parameter int MAX_ENTITIES = sal_pkg::MAX_ENTITIES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  sal_pkg::req_type               req_payload,
   input  logic                           csr_write_en,
   input  logic [sal_pkg::RAD_W-1:0]      csr_write_data,
   output logic                           rsp_strobe,
   output sal_pkg::rsp_type               rsp_payload
);
   import sal_pkg::*;

   localparam int IW = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
   localparam int CW = $clog2(MAX_ENTITIES + 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_INS    = 4'd1;
   localparam logic [3:0] ST_RMV    = 4'd2;
   localparam logic [3:0] ST_WBEGIN = 4'd3;
   localparam logic [3:0] ST_RD     = 4'd4;
   localparam logic [3:0] ST_SQ     = 4'd5;
   localparam logic [3:0] ST_CMP    = 4'd6;
   localparam logic [3:0] ST_EV2    = 4'd7;
   localparam logic [3:0] ST_OLD_A  = 4'd8;
   localparam logic [3:0] ST_OLD_B  = 4'd9;
   localparam logic [3:0] ST_NEW_A  = 4'd10;
   localparam logic [3:0] ST_NEW_B  = 4'd11;
   localparam logic [3:0] ST_DONE   = 4'd12;

   logic [3:0] state_ff, state_in;
   logic [OP_W-1:0] op_ff, op_in;
   logic [ENT_W-1:0] ent_ff, ent_in;
   logic signed [COORD_W-1:0] px_ff, px_in, py_ff, py_in, cx_ff, cx_in, cy_ff, cy_in;
   logic [LIM_W-1:0] limit_ff, limit_in, found_ff, found_in;
   logic [IW-1:0] pos_ff, pos_in, idx_ff, idx_in, em_ff, em_in;
   logic [IW-1:0] old_num_ff, old_num_in, new_num_ff, new_num_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic right_ff, right_in, phase_new_ff, phase_new_in;
   logic [ENT_NUM-1:0] present_ff, present_in;
   logic [ENT_NUM-1:0] old_mask_ff, old_mask_in, new_mask_ff, new_mask_in;
   logic [ENT_W-1:0] old_list_ff [MAX_ENTITIES];
   logic [ENT_W-1:0] old_list_in [MAX_ENTITIES];
   logic [ENT_W-1:0] new_list_ff [MAX_ENTITIES];
   logic [ENT_W-1:0] new_list_in [MAX_ENTITIES];
   logic signed [16:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [31:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [ENT_W-1:0] nb_ent_ff, nb_ent_in;
   logic signed [COORD_W-1:0] nb_x_ff, nb_x_in, nb_y_ff, nb_y_in;
   logic [RAD_W-1:0] radius_ff;
   logic [2*RAD_W-1:0] rsq_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   slot_type      slot_q [MAX_ENTITIES];
   cell_cmd_type  cmd    [MAX_ENTITIES];
   cell_flag_type flags  [MAX_ENTITIES];
   slot_type      new_slot, empty_slot, rd_slot;

   logic [IW-1:0] hit_pos, ins_pos, rs_idx, adv_idx;
   logic rs_ok, adv_ok, adv_right, req_valid;
   logic [3:0] end_st;
   logic signed [16:0] gap;
   logic brk, in_view;
   logic signed [33:0] prodx, prody;

   assign new_slot   = '{used: 1'b1, entity: ent_ff, x: px_ff, y: py_ff};
   assign empty_slot = '0;

   for (genvar j = 0; j < MAX_ENTITIES; j++) begin : g_cell
      always_comb begin
         cmd[j].load       = (state_ff == ST_INS) && (ins_pos == IW'(j));
         cmd[j].take_left  = (state_ff == ST_INS) && (IW'(j) > ins_pos);
         cmd[j].take_right = (state_ff == ST_RMV) && (IW'(j) >= pos_ff);
      end
      sal_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd[j]),
         .new_slot   (new_slot),
         .left_slot  ((j == 0) ? new_slot : slot_q[(j == 0) ? 0 : j - 1]),
         .right_slot ((j == MAX_ENTITIES - 1) ? empty_slot
                                              : slot_q[(j == MAX_ENTITIES - 1) ? j : j + 1]),
         .key_x      (px_ff),
         .key_entity (req_payload.entity),
         .slot       (slot_q[j]),
         .flags      (flags[j])
      );
   end

   always_comb begin
      hit_pos = '0;
      ins_pos = IW'(cnt_ff);
      for (int j = MAX_ENTITIES - 1; j >= 0; j--) begin
         if (flags[j].hit) hit_pos = IW'(j);
         if (flags[j].x_ge) ins_pos = IW'(j);
      end
   end

   assign rd_slot   = slot_q[idx_ff];
   assign req_valid = int'(req_payload.entity) < MAX_ENTITIES;

   // Walk order: left of the center slot going outward, then right of it.
   assign rs_ok  = (CW'(pos_ff) + CW'(1)) < cnt_ff;
   assign rs_idx = pos_ff + IW'(1);

   always_comb begin
      if (!right_ff) begin
         if (idx_ff != '0) begin
            adv_ok    = 1'b1;
            adv_right = 1'b0;
            adv_idx   = idx_ff - IW'(1);
         end else begin
            adv_ok    = rs_ok;
            adv_right = 1'b1;
            adv_idx   = rs_idx;
         end
      end else begin
         adv_ok    = (CW'(idx_ff) + CW'(1)) < cnt_ff;
         adv_right = 1'b1;
         adv_idx   = idx_ff + IW'(1);
      end
   end

   always_comb begin
      unique case (op_ff)
         OP_ENTER: end_st = ST_DONE;
         OP_QUERY: end_st = ST_DONE;
         OP_LEAVE: end_st = ST_RMV;
         OP_MOVE:  end_st = phase_new_ff ? ST_OLD_A : ST_RMV;
         default:  end_st = ST_DONE;
      endcase
   end

   assign dx_in  = $signed({cx_ff[COORD_W-1], cx_ff}) - $signed({rd_slot.x[COORD_W-1], rd_slot.x});
   assign dy_in  = $signed({cy_ff[COORD_W-1], cy_ff}) - $signed({rd_slot.y[COORD_W-1], rd_slot.y});
   assign gap    = right_ff ? -dx_in : dx_in;
   assign brk    = gap > $signed({2'b00, radius_ff});
   assign prodx  = dx_ff * dx_ff;
   assign prody  = dy_ff * dy_ff;
   assign sqx_in = prodx[31:0];
   assign sqy_in = prody[31:0];
   assign in_view = ({1'b0, sqx_ff} + {1'b0, sqy_ff}) <= {3'b000, rsq_ff};
   assign nb_ent_in = rd_slot.entity;
   assign nb_x_in   = rd_slot.x;
   assign nb_y_in   = rd_slot.y;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      ent_in       = ent_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      limit_in     = limit_ff;
      found_in     = found_ff;
      pos_in       = pos_ff;
      idx_in       = idx_ff;
      em_in        = em_ff;
      old_num_in   = old_num_ff;
      new_num_in   = new_num_ff;
      cnt_in       = cnt_ff;
      right_in     = right_ff;
      phase_new_in = phase_new_ff;
      present_in   = present_ff;
      old_mask_in  = old_mask_ff;
      new_mask_in  = new_mask_ff;
      old_list_in  = old_list_ff;
      new_list_in  = new_list_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.subject = ent_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in        = req_payload.operation;
               ent_in       = req_payload.entity;
               px_in        = req_payload.pos_x;
               py_in        = req_payload.pos_y;
               limit_in     = req_payload.query_limit;
               found_in     = '0;
               em_in        = '0;
               phase_new_in = 1'b0;
               old_num_in   = '0;
               new_num_in   = '0;
               old_mask_in  = '0;
               new_mask_in  = '0;
               pos_in       = hit_pos;
               cx_in        = slot_q[hit_pos].x;
               cy_in        = slot_q[hit_pos].y;
               if (req_payload.operation == OP_ENTER) begin
                  if (!req_valid || present_ff[req_payload.entity] ||
                      (int'(cnt_ff) >= MAX_ENTITIES)) begin
                     rsp_valid_in   = 1'b1;
                     rsp_in.kind    = KIND_DONE;
                     rsp_in.subject = req_payload.entity;
                     rsp_in.status  = 1'b1;
                     rsp_in.is_last = 1'b1;
                  end else begin
                     present_in[req_payload.entity] = 1'b1;
                     state_in = ST_INS;
                  end
               end else if (!(req_valid && present_ff[req_payload.entity])) begin
                  rsp_valid_in   = 1'b1;
                  rsp_in.kind    = KIND_DONE;
                  rsp_in.subject = req_payload.entity;
                  rsp_in.status  = 1'b1;
                  rsp_in.is_last = 1'b1;
               end else begin
                  state_in = ST_WBEGIN;
               end
            end
         end
         ST_INS: begin
            pos_in       = ins_pos;
            cnt_in       = cnt_ff + CW'(1);
            cx_in        = px_ff;
            cy_in        = py_ff;
            phase_new_in = 1'b1;
            state_in     = ST_WBEGIN;
         end
         ST_RMV: begin
            cnt_in = cnt_ff - CW'(1);
            if (op_ff == OP_LEAVE) begin
               present_in[ent_ff] = 1'b0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_INS;
            end
         end
         ST_WBEGIN: begin
            if (pos_ff != '0) begin
               right_in = 1'b0;
               idx_in   = pos_ff - IW'(1);
               state_in = ST_RD;
            end else if (rs_ok) begin
               right_in = 1'b1;
               idx_in   = rs_idx;
               state_in = ST_RD;
            end else begin
               state_in = end_st;
            end
         end
         ST_RD: begin
            if (brk) begin
               if (!right_ff && rs_ok) begin
                  right_in = 1'b1;
                  idx_in   = rs_idx;
               end else begin
                  state_in = end_st;
               end
            end else begin
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            state_in = ST_CMP;
         end
         ST_CMP, ST_EV2: begin
            if (adv_ok) begin
               right_in = adv_right;
               idx_in   = adv_idx;
               state_in = ST_RD;
            end else begin
               state_in = end_st;
            end
            if (state_ff == ST_EV2) begin
               rsp_valid_in   = 1'b1;
               rsp_in.kind    = (op_ff == OP_ENTER) ? KIND_ENTER : KIND_LEAVE;
               rsp_in.subject = nb_ent_ff;
               rsp_in.object  = ent_ff;
               rsp_in.event_x = nb_x_ff;
               rsp_in.event_y = nb_y_ff;
            end else if (in_view) begin
               unique case (op_ff)
                  OP_ENTER, OP_LEAVE: begin
                     rsp_valid_in   = 1'b1;
                     rsp_in.kind    = (op_ff == OP_ENTER) ? KIND_ENTER : KIND_LEAVE;
                     rsp_in.object  = nb_ent_ff;
                     rsp_in.event_x = cx_ff;
                     rsp_in.event_y = cy_ff;
                     state_in       = ST_EV2;
                     right_in       = right_ff;
                     idx_in         = idx_ff;
                  end
                  OP_QUERY: begin
                     if (found_ff < limit_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.kind   = KIND_NEAR;
                        rsp_in.object = nb_ent_ff;
                        found_in      = found_ff + LIM_W'(1);
                     end
                  end
                  OP_MOVE: begin
                     if (phase_new_ff) begin
                        new_list_in[new_num_ff] = nb_ent_ff;
                        new_num_in              = new_num_ff + IW'(1);
                        new_mask_in[nb_ent_ff]  = 1'b1;
                     end else begin
                        old_list_in[old_num_ff] = nb_ent_ff;
                        old_num_in              = old_num_ff + IW'(1);
                        old_mask_in[nb_ent_ff]  = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_OLD_A: begin
            if (em_ff == old_num_ff) begin
               em_in    = '0;
               state_in = ST_NEW_A;
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_in.kind    = new_mask_ff[old_list_ff[em_ff]] ? KIND_MOVE : KIND_LEAVE;
               rsp_in.object  = old_list_ff[em_ff];
               rsp_in.event_x = px_ff;
               rsp_in.event_y = py_ff;
               state_in       = ST_OLD_B;
            end
         end
         ST_OLD_B: begin
            rsp_valid_in   = 1'b1;
            rsp_in.kind    = new_mask_ff[old_list_ff[em_ff]] ? KIND_MOVE : KIND_LEAVE;
            rsp_in.subject = old_list_ff[em_ff];
            rsp_in.object  = ent_ff;
            rsp_in.event_x = px_ff;
            rsp_in.event_y = py_ff;
            em_in          = em_ff + IW'(1);
            state_in       = ST_OLD_A;
         end
         ST_NEW_A: begin
            if (em_ff == new_num_ff) begin
               state_in = ST_DONE;
            end else if (old_mask_ff[new_list_ff[em_ff]]) begin
               em_in = em_ff + IW'(1);
            end else begin
               rsp_valid_in   = 1'b1;
               rsp_in.kind    = KIND_ENTER;
               rsp_in.object  = new_list_ff[em_ff];
               rsp_in.event_x = px_ff;
               rsp_in.event_y = py_ff;
               state_in       = ST_NEW_B;
            end
         end
         ST_NEW_B: begin
            rsp_valid_in   = 1'b1;
            rsp_in.kind    = KIND_ENTER;
            rsp_in.subject = new_list_ff[em_ff];
            rsp_in.object  = ent_ff;
            rsp_in.event_x = px_ff;
            rsp_in.event_y = py_ff;
            em_in          = em_ff + IW'(1);
            state_in       = ST_NEW_A;
         end
         ST_DONE: begin
            rsp_valid_in       = 1'b1;
            rsp_in.kind        = KIND_DONE;
            rsp_in.found_count = found_ff;
            rsp_in.is_last     = 1'b1;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         present_ff   <= '0;
         radius_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         present_ff   <= present_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) radius_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ent_ff       <= ent_in;
      px_ff        <= px_in;
      py_ff        <= py_in;
      cx_ff        <= cx_in;
      cy_ff        <= cy_in;
      limit_ff     <= limit_in;
      found_ff     <= found_in;
      pos_ff       <= pos_in;
      idx_ff       <= idx_in;
      em_ff        <= em_in;
      old_num_ff   <= old_num_in;
      new_num_ff   <= new_num_in;
      right_ff     <= right_in;
      phase_new_ff <= phase_new_in;
      old_mask_ff  <= old_mask_in;
      new_mask_ff  <= new_mask_in;
      old_list_ff  <= old_list_in;
      new_list_ff  <= new_list_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      nb_ent_ff    <= nb_ent_in;
      nb_x_ff      <= nb_x_in;
      nb_y_ff      <= nb_y_in;
      rsq_ff       <= radius_ff * radius_ff;
      rsp_ff       <= rsp_in;
   end

   assign busy        = state_ff != ST_IDLE;
   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> rtl/sal_cell.sv
module sal_cell (
   input  logic                              clock,
   input  logic                              reset,
   input  sal_pkg::cell_cmd_type             cmd,
   input  sal_pkg::slot_type                 new_slot,
   input  sal_pkg::slot_type                 left_slot,
   input  sal_pkg::slot_type                 right_slot,
   input  logic signed [sal_pkg::COORD_W-1:0] key_x,
   input  logic [sal_pkg::ENT_W-1:0]          key_entity,
   output sal_pkg::slot_type                 slot,
   output sal_pkg::cell_flag_type            flags
);
   import sal_pkg::*;

   slot_type slot_ff;

   always_ff @(posedge clock) begin
      priority if (reset) begin
         slot_ff.used <= 1'b0;
      end else if (cmd.load) begin
         slot_ff <= new_slot;
      end else if (cmd.take_left) begin
         slot_ff <= left_slot;
      end else if (cmd.take_right) begin
         slot_ff <= right_slot;
      end
   end

   assign slot       = slot_ff;
   assign flags.x_ge = slot_ff.used && (slot_ff.x >= key_x);
   assign flags.hit  = slot_ff.used && (slot_ff.entity == key_entity);

endmodule
